// ===== sv/unique_value_set_table_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the unique value set table
// Short wrappers that build clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_VALUE_SET_TABLE_UNIT_MACROS_SVH
`define UNIQUE_VALUE_SET_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UVST_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UVST_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/uvst_pkg.sv =====
// ----------------------------------------------------------------------------
// Unique value set table package
// Field widths, operation and status codes shared by the table modules.
// ----------------------------------------------------------------------------
package uvst_pkg;

    localparam int UVST_CAPACITY = 16;

    localparam int KEY_W    = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes. The unused code behaves as a find.
    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_FIND   = 2'd2;
    localparam op_t OP_UNUSED = 2'd3;

    // Result status codes.
    localparam status_t ST_INSERTED = 3'd0;
    localparam status_t ST_PRESENT  = 3'd1;
    localparam status_t ST_REMOVED  = 3'd2;
    localparam status_t ST_MISSING  = 3'd3;
    localparam status_t ST_FULL     = 3'd4;
    localparam status_t ST_FOUND    = 3'd5;

endpackage

// ===== sv/unique_value_set_table_unit.sv =====
// ----------------------------------------------------------------------------
// Unique value set table
// A set of distinct 64-bit values kept in insertion order in a row of cells,
// with insert, remove and find operations.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  op, key_value
// out      output     out_valid / out_stall status, position, entry_count
//
// Each item is accepted and then the whole cell row shifts through one full
// rotation past the head comparator, with a single compare at the head cell.
// A new item is taken only once the previous one has finished its rotation.
// The result register is loaded on the last shift; if it still holds an
// untaken result then, the row waits on that last shift until it is taken.
// Reset clears the entry count and all control state; stored entries are
// left as they are, since only the first entry_count of them are ever read.
//
module unique_value_set_table_unit
    import uvst_pkg::*;
#(
    parameter int CAPACITY = UVST_CAPACITY
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  op_t     op,
    input  key_t    key_value,
    output logic    out_valid,
    input  logic    out_stall,
    output status_t status,
    output logic [POS_W-1:0] position,
    output logic [CNT_W-1:0] entry_count
);

`include "unique_value_set_table_unit_macros.svh"

    // Cell row. Cell 0 is the head that the sequencer compares against the
    // key; the last cell is loaded from the tail value the sequencer picks.
    key_t cell_q [CAPACITY];
    key_t tail_value;
    logic shift;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == CAPACITY - 1)
            begin : g_tail
                uvst_cell u_cell
                (
                    .clk   (clk),
                    .shift (shift),
                    .d     (tail_value),
                    .q     (cell_q[gi])
                );
            end
            else
            begin : g_body
                uvst_cell u_cell
                (
                    .clk   (clk),
                    .shift (shift),
                    .d     (cell_q[gi+1]),
                    .q     (cell_q[gi])
                );
            end
        end
    endgenerate

    // The sequencer walks one rotation per item. During an insert the key
    // enters the row at the first free place; during a remove the entry one
    // place ahead of the head replaces each entry from the match onward.
    uvst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key_value   (key_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .position    (position),
        .entry_count (entry_count),
        .head_value  (cell_q[0]),
        .next_value  (cell_q[1]),
        .shift       (shift),
        .tail_value  (tail_value)
    );

    // A full table reports the whole capacity as its count.
    `UVST_ASSERT_NOW(a_full_count, clk, rst_n, (out_valid && status == ST_FULL), (entry_count == CNT_W'(CAPACITY)), ("table full reported with wrong count"))

    // Results without an affected entry carry position zero.
    `UVST_ASSERT_NOW(a_none_pos, clk, rst_n, (out_valid && (status == ST_MISSING || status == ST_FULL)), (position == '0), ("nonzero position without an entry"))

    // Once an item is taken the block works on it and takes no other.
    `UVST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall), (in_stall), ("second item taken during a sweep"))

    // The row only moves while an item is in progress.
    `UVST_ASSERT_NOW(a_shift_busy, clk, rst_n, (shift), (in_stall), ("cell row shifted while idle"))

endmodule

// ===== sv/uvst_cell.sv =====
// ----------------------------------------------------------------------------
// Unique value set table storage cell
// Holds one table entry and loads its neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module uvst_cell
    import uvst_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  key_t d,
    output key_t q
);

    key_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

// ===== sv/uvst_ctrl.sv =====
// ----------------------------------------------------------------------------
// Unique value set table sequencer
// Drives one full rotation of the cell row per item, compares the head
// entry, picks what re-enters at the tail and forms the result.
// ----------------------------------------------------------------------------
module uvst_ctrl
    import uvst_pkg::*;
#(
    parameter int CAPACITY = UVST_CAPACITY
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  op_t     op,
    input  key_t    key_value,
    output logic    out_valid,
    input  logic    out_stall,
    output status_t status,
    output logic [POS_W-1:0] position,
    output logic [CNT_W-1:0] entry_count,
    input  key_t    head_value,
    input  key_t    next_value,
    output logic    shift,
    output key_t    tail_value
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);

    logic             busy_reg;
    logic [IDX_W-1:0] step_reg;
    logic [IDX_W-1:0] step_next;
    logic             found_reg;
    logic [IDX_W-1:0] at_reg;
    op_t              op_reg;
    key_t             key_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [POS_W-1:0] position_reg;
    logic [POS_W-1:0] position_next;
    logic [CNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0] entry_count_next;

    logic             accept;
    logic             last;
    logic             out_free;
    logic             advance;
    logic             in_range;
    logic             hit;
    logic             found_now;
    logic [IDX_W-1:0] at_now;
    logic [IDX_W-1:0] res_pos;
    logic [IDX_W+POS_W-1:0] pos_wide;
    logic [CW+CNT_W-1:0]    cnt_wide;

    assign accept   = in_valid && !busy_reg;
    assign last     = (step_reg == IDX_W'(CAPACITY - 1));
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = busy_reg && (!last || out_free);

    // The head cell holds entry number step_reg during the sweep.
    assign in_range  = (CW'(step_reg) < count_reg);
    assign hit       = in_range && !found_reg && (head_value == key_reg);
    assign found_now = found_reg || hit;
    assign at_now    = hit ? step_reg : at_reg;
    assign step_next = last ? '0 : step_reg + IDX_W'(1);

    // After a removed entry has passed the head, every tail write takes
    // the entry one place further on, which closes the gap. An insert
    // drops the key in at the first free place.
    always_comb
    begin
        tail_value = head_value;
        if (op_reg == OP_REMOVE && found_now)
        begin
            tail_value = next_value;
        end
        else if (op_reg == OP_INSERT && !found_reg && CW'(step_reg) == count_reg)
        begin
            tail_value = key_reg;
        end
    end

    always_comb
    begin
        status_next = ST_MISSING;
        res_pos     = '0;
        count_next  = count_reg;
        unique case (op_reg)
            OP_INSERT:
            begin
                if (found_now)
                begin
                    status_next = ST_PRESENT;
                    res_pos     = at_now;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    res_pos     = count_reg[IDX_W-1:0];
                    count_next  = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found_now)
                begin
                    status_next = ST_REMOVED;
                    res_pos     = at_now;
                    count_next  = count_reg - CW'(1);
                end
            end
            default:
            begin
                if (found_now)
                begin
                    status_next = ST_FOUND;
                    res_pos     = at_now;
                end
            end
        endcase
    end

    assign pos_wide         = (IDX_W + POS_W)'(res_pos);
    assign position_next    = pos_wide[POS_W-1:0];
    assign cnt_wide         = (CW + CNT_W)'(count_next);
    assign entry_count_next = cnt_wide[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg  <= 1'b1;
                step_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (advance)
            begin
                step_reg  <= step_next;
                found_reg <= found_now;
                if (last)
                begin
                    busy_reg  <= 1'b0;
                    count_reg <= count_next;
                end
            end

            if (advance && last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            key_reg <= key_value;
        end
        if (advance)
        begin
            at_reg <= at_now;
        end
        if (advance && last)
        begin
            status_reg      <= status_next;
            position_reg    <= position_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign in_stall    = busy_reg;
    assign shift       = advance;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Unique value set table testbench
// Drives insert, remove and find items into the table with random gaps on the
// input side and random stalls on the result side. A scoreboard keeps its own
// copy of the table, works out the status, position and count that every
// accepted item should produce, and compares them with each accepted result.
// ----------------------------------------------------------------------------
module tb_top;
    import uvst_pkg::*;

    localparam int          CAP         = UVST_CAPACITY;
    // Time an item spends inside the block, used to size the final wait.
    localparam int          ITEM_CYCLES = CAP + 1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          PHASES      = 14;
    localparam int          PHASE_ITEMS = 50;
    localparam int          POOL_SIZE   = 24;

    // One expected result of the table.
    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] entry_count;
    } outcome_t;

    // Scoreboard: holds a private copy of the table, predicts the outcome of
    // each accepted item and checks the results in order against it.
    class uvst_scoreboard;
        key_t        stored_keys[CAP];
        int unsigned stored_count;
        outcome_t    outcome_queue[$];
        int unsigned errors;
        int unsigned results_checked;
        int unsigned full_hits;
        int unsigned present_hits;
        int unsigned op_hits[4];

        function new();
            stored_count    = 0;
            errors          = 0;
            results_checked = 0;
            full_hits       = 0;
            present_hits    = 0;
            foreach (op_hits[i])
                op_hits[i] = 0;
        endfunction

        // Apply one accepted item to the private table and queue its outcome.
        function void note_input(op_t code, key_t key);
            int unsigned hit;
            outcome_t    res;
            hit = stored_count;
            for (int unsigned k = 0; k < stored_count; k++)
            begin
                if (stored_keys[k] == key && hit == stored_count)
                    hit = k;
            end
            op_hits[code]++;
            res.position = '0;
            case (code)
                OP_INSERT:
                begin
                    if (hit < stored_count)
                    begin
                        res.status   = ST_PRESENT;
                        res.position = hit[POS_W-1:0];
                        present_hits++;
                    end
                    else if (stored_count >= CAP)
                    begin
                        res.status = ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        stored_keys[stored_count] = key;
                        res.status   = ST_INSERTED;
                        res.position = stored_count[POS_W-1:0];
                        stored_count++;
                    end
                end
                OP_REMOVE:
                begin
                    if (hit < stored_count)
                    begin
                        for (int unsigned k = hit; k + 1 < stored_count; k++)
                            stored_keys[k] = stored_keys[k + 1];
                        stored_count--;
                        res.status   = ST_REMOVED;
                        res.position = hit[POS_W-1:0];
                    end
                    else
                        res.status = ST_MISSING;
                end
                default:
                begin
                    // The unused code is a plain find as well.
                    if (hit < stored_count)
                    begin
                        res.status   = ST_FOUND;
                        res.position = hit[POS_W-1:0];
                    end
                    else
                        res.status = ST_MISSING;
                end
            endcase
            res.entry_count = stored_count[CNT_W-1:0];
            outcome_queue.push_back(res);
        endfunction

        task report(string msg);
            $display("ERROR at cycle %0d: %s", tb_top.cycle_count, msg);
            errors++;
        endtask

        // Compare one accepted result with the oldest outcome still waiting.
        task check_result(status_t st, logic [POS_W-1:0] pos, logic [CNT_W-1:0] cnt);
            outcome_t exp_res;
            if (outcome_queue.size() == 0)
            begin
                report($sformatf("result with nothing expected: status %0d pos %0d count %0d",
                                 st, pos, cnt));
                return;
            end
            exp_res = outcome_queue.pop_front();
            results_checked++;
            if (st !== exp_res.status)
                report($sformatf("result %0d status %0d, expected %0d",
                                 results_checked, st, exp_res.status));
            if (pos !== exp_res.position)
                report($sformatf("result %0d position %0d, expected %0d",
                                 results_checked, pos, exp_res.position));
            if (cnt !== exp_res.entry_count)
                report($sformatf("result %0d entry_count %0d, expected %0d",
                                 results_checked, cnt, exp_res.entry_count));
        endtask
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    op_t              op          = OP_INSERT;
    key_t             key_value   = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    status_t          status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;

    int unsigned      cycle_count = 0;
    // When set, neither side inserts gaps or stalls.
    bit               quiet       = 1'b0;
    key_t             key_pool[POOL_SIZE];

    uvst_scoreboard   sb = new();

    unique_value_set_table_unit #(
        .CAPACITY(CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .key_value(key_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .position(position),
        .entry_count(entry_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a run that is still going at the limit has hung.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.outcome_queue.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Monitor: both handshakes are sampled at the rising edge, before any of
    // this edge's updates take effect. The result is checked before the new
    // input is noted, since a result can only belong to an earlier item.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, position, entry_count);
        if (rst_n && in_valid && !in_stall)
            sb.note_input(op, key_value);
    end

    // Send one item. A gap before it lowers valid for a random number of
    // cycles; with no gap the next item follows right after the last one is
    // taken, so valid stays high without a second assignment in that step.
    task send_item(op_t code, key_t key);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= code;
        key_value <= key;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Pick an operation with the given insert and remove weights in percent.
    // The last five percent go to the unused code, which behaves as a find.
    function automatic op_t pick_op(int unsigned ins_pct, int unsigned rem_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + rem_pct)
            return OP_REMOVE;
        if (r < 95)
            return OP_FIND;
        return OP_UNUSED;
    endfunction

    // Most keys come from a small pool so that hits, duplicates and a full
    // table are common; the rest are fresh random patterns.
    function automatic key_t pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // Result side: before each result hold stall high for a random number of
    // cycles, then take the next result that shows up.
    initial
    begin : result_sink
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 16);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin : stimulus
        int unsigned ins_pct;
        int unsigned rem_pct;

        // The pool starts with the signed zeros, a NaN and all ones, so the
        // bit-pattern comparison is exercised in the random part as well.
        key_pool[0] = 64'h0000_0000_0000_0000;
        key_pool[1] = 64'h8000_0000_0000_0000;
        key_pool[2] = 64'h7FF8_0000_0000_0001;
        key_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty table misses on find and remove.
        send_item(OP_FIND,   64'h0);
        send_item(OP_REMOVE, 64'h0);
        // Positive and negative zero are distinct entries, and a repeated
        // insert reports the value as already present.
        send_item(OP_INSERT, 64'h0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000);
        send_item(OP_INSERT, 64'h0);
        // A NaN pattern matches itself; the unused code finds it.
        send_item(OP_INSERT, 64'h7FF8_0000_0000_0001);
        send_item(OP_UNUSED, 64'h7FF8_0000_0000_0001);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        // Fill the rest of the table.
        for (int i = 0; i < CAP - 4; i++)
            send_item(OP_INSERT, 64'h1000 + i);
        // A new value bounces off the full table, while a stored one is
        // still reported as already present.
        send_item(OP_INSERT, 64'h5555_AAAA_5555_AAAA);
        send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        // Remove from the middle and from the head; later entries move down.
        send_item(OP_REMOVE, 64'h8000_0000_0000_0000);
        send_item(OP_REMOVE, 64'h0);
        send_item(OP_FIND,   64'hFFFF_FFFF_FFFF_FFFF);

        // Random part in phases that alternate between filling and draining
        // the table, so it swings between empty and full many times. Some
        // phases run without any gaps or stalls.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 2 == 0)
            begin
                ins_pct = 65;
                rem_pct = 15;
            end
            else
            begin
                ins_pct = 20;
                rem_pct = 60;
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(pick_op(ins_pct, rem_pct), pick_key());
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // Drain: wait for every outstanding result, then a little longer so
        // that a stray extra result would still be caught.
        while (sb.outcome_queue.size() != 0)
            @(posedge clk);
        repeat (4 * ITEM_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d inserts, %0d removes, %0d finds, %0d unused-code finds.",
                 sb.results_checked, sb.op_hits[OP_INSERT], sb.op_hits[OP_REMOVE],
                 sb.op_hits[OP_FIND], sb.op_hits[OP_UNUSED]);
        $display("The table turned an insert away as full %0d times and saw %0d repeated inserts.",
                 sb.full_hits, sb.present_hits);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
